FILE: src/u2u8_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
// Used by the encoder, the result emitter and the top level; depends on nothing.
package u2u8_pkg;

	// Status codes carried on each result item.
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_SURR_ERR = 2'd1;
	localparam logic [1:0] STATUS_FULL_ERR = 2'd2;

	// Surrogate ranges and encoding constants.
	localparam logic [15:0] HI_SURR_FIRST = 16'hD800;
	localparam logic [15:0] HI_SURR_LAST  = 16'hDBFF;
	localparam logic [15:0] LO_SURR_FIRST = 16'hDC00;
	localparam logic [15:0] LO_SURR_LAST  = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE     = 21'h10000;
	localparam logic [20:0] LIMIT_1BYTE   = 21'h80;
	localparam logic [20:0] LIMIT_2BYTE   = 21'h800;
	localparam logic [7:0]  LEAD_2BYTE    = 8'hC0;
	localparam logic [7:0]  LEAD_3BYTE    = 8'hE0;
	localparam logic [7:0]  LEAD_4BYTE    = 8'hF0;
	localparam logic [7:0]  CONT_MARK     = 8'h80;
	localparam logic [5:0]  CONT_MASK     = 6'h3F;

	// Most results that one input item can cause.
	localparam int MAX_RESULTS = 5;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic [1:0]  status;
		logic [15:0] byte_count;
		logic        last;
	} out_item_t;

	// Per-string state kept between input items.
	typedef struct packed {
		logic [9:0]  pending_high;
		logic        pending_valid;
		logic [15:0] bytes_written;
		logic        dropping;
	} str_state_t;

	// All results caused by one input item, in delivery order.
	typedef struct packed {
		out_item_t [MAX_RESULTS-1:0] res;
		logic [2:0]                  num;
	} bundle_t;

endpackage

FILE: src/u2u8_encoder.sv
// Combinational encoder: turns one UTF-16 code unit plus the string state into
// the UTF-8 result items it causes and the next string state. Uses u2u8_pkg.
module u2u8_encoder (
	input  u2u8_pkg::in_item_t   item,
	input  u2u8_pkg::str_state_t st,
	input  logic [15:0]          capacity,
	output u2u8_pkg::bundle_t    bundle,
	output u2u8_pkg::str_state_t st_next
);

	logic        is_hi;
	logic        is_lo;
	logic [20:0] cp;
	logic [7:0]  bytes [4];
	logic [2:0]  nbytes;
	logic [16:0] sum;
	logic [15:0] nbw;

	assign is_hi = item.code_unit inside {[u2u8_pkg::HI_SURR_FIRST:u2u8_pkg::HI_SURR_LAST]};
	assign is_lo = item.code_unit inside {[u2u8_pkg::LO_SURR_FIRST:u2u8_pkg::LO_SURR_LAST]};

	// Code point from a held high surrogate and a low one, or the unit itself.
	always_comb begin
		if (st.pending_valid) begin
			cp = {1'b0, st.pending_high, item.code_unit[9:0]} + u2u8_pkg::SUPP_BASE;
		end else begin
			cp = {5'd0, item.code_unit};
		end
	end

	// UTF-8 byte sequence of the code point.
	always_comb begin
		bytes[0] = 8'd0;
		bytes[1] = 8'd0;
		bytes[2] = 8'd0;
		bytes[3] = 8'd0;
		if (cp < u2u8_pkg::LIMIT_1BYTE) begin
			bytes[0] = cp[7:0];
			nbytes = 3'd1;
		end else if (cp < u2u8_pkg::LIMIT_2BYTE) begin
			bytes[0] = u2u8_pkg::LEAD_2BYTE | {3'd0, cp[10:6]};
			bytes[1] = u2u8_pkg::CONT_MARK | {2'd0, cp[5:0] & u2u8_pkg::CONT_MASK};
			nbytes = 3'd2;
		end else if (cp < u2u8_pkg::SUPP_BASE) begin
			bytes[0] = u2u8_pkg::LEAD_3BYTE | {4'd0, cp[15:12]};
			bytes[1] = u2u8_pkg::CONT_MARK | {2'd0, cp[11:6]};
			bytes[2] = u2u8_pkg::CONT_MARK | {2'd0, cp[5:0]};
			nbytes = 3'd3;
		end else begin
			bytes[0] = u2u8_pkg::LEAD_4BYTE | {5'd0, cp[20:18]};
			bytes[1] = u2u8_pkg::CONT_MARK | {2'd0, cp[17:12]};
			bytes[2] = u2u8_pkg::CONT_MARK | {2'd0, cp[11:6]};
			bytes[3] = u2u8_pkg::CONT_MARK | {2'd0, cp[5:0]};
			nbytes = 3'd4;
		end
	end

	assign sum = {1'b0, st.bytes_written} + {14'd0, nbytes};
	assign nbw = sum[15:0];

	// Result selection and state update.
	always_comb begin
		logic       fail;
		logic [1:0] fail_status;
		fail = 1'b0;
		fail_status = u2u8_pkg::STATUS_SURR_ERR;
		bundle = '0;
		st_next = st;
		if (st.dropping) begin
			if (item.end_of_string) begin
				st_next = '0;
			end
		end else if (st.pending_valid && !is_lo) begin
			fail = 1'b1;
		end else if (!st.pending_valid && is_hi) begin
			if (item.end_of_string) begin
				fail = 1'b1;
			end else begin
				st_next.pending_high = item.code_unit[9:0];
				st_next.pending_valid = 1'b1;
			end
		end else if (!st.pending_valid && is_lo) begin
			fail = 1'b1;
		end else if (sum > {1'b0, capacity}) begin
			fail = 1'b1;
			fail_status = u2u8_pkg::STATUS_FULL_ERR;
		end else begin
			// Data bytes, each counting itself.
			for (int i = 0; i < 4; i++) begin
				if (3'(i) < nbytes) begin
					bundle.res[i] = '{out_byte: bytes[i], status: u2u8_pkg::STATUS_OK,
						byte_count: st.bytes_written + 16'(i + 1), last: 1'b0};
				end
			end
			if (item.end_of_string) begin
				// Terminator, or a full error when it does not fit.
				for (int i = 0; i < u2u8_pkg::MAX_RESULTS; i++) begin
					if (3'(i) == nbytes) begin
						bundle.res[i] = '{out_byte: 8'd0,
							status: (nbw >= capacity) ? u2u8_pkg::STATUS_FULL_ERR
								: u2u8_pkg::STATUS_OK,
							byte_count: nbw, last: 1'b1};
					end
				end
				bundle.num = nbytes + 3'd1;
				st_next = '0;
			end else begin
				bundle.num = nbytes;
				st_next.bytes_written = nbw;
				st_next.pending_valid = 1'b0;
				st_next.pending_high = 10'd0;
			end
		end
		// An error ends the string with a single result.
		if (fail) begin
			bundle.res[0] = '{out_byte: 8'd0, status: fail_status,
				byte_count: st.bytes_written, last: 1'b1};
			bundle.num = 3'd1;
			st_next = '0;
			st_next.dropping = !item.end_of_string;
			st_next.bytes_written = item.end_of_string ? 16'd0 : st.bytes_written;
		end
	end

endmodule

FILE: src/u2u8_emitter.sv
// Result buffer: holds one item's results; hands out one per cycle when out_ready.
// Uses u2u8_pkg types; loaded by the top level from u2u8_encoder.
module u2u8_emitter (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  u2u8_pkg::bundle_t     bundle,
	output logic                  free,
	output logic                  out_valid,
	input  logic                  out_ready,
	output u2u8_pkg::out_item_t   out_item
);

	u2u8_pkg::out_item_t [u2u8_pkg::MAX_RESULTS-1:0] res_q;
	logic [2:0] cnt_q;
	logic [2:0] idx_q;
	logic       take;

	assign out_valid = idx_q != cnt_q;
	assign out_item = res_q[idx_q];
	assign take = out_valid && out_ready;
	// Free when empty or when the final result leaves this cycle.
	assign free = !out_valid || (take && (idx_q + 3'd1 == cnt_q));

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= bundle.res;
		end
	end

	// Delivery position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			idx_q <= 3'd0;
		end else if (load) begin
			cnt_q <= bundle.num;
			idx_q <= 3'd0;
		end else if (take) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= cnt_q && cnt_q <= 3'(u2u8_pkg::MAX_RESULTS))
		else $error("emitter position beyond its fill");

	a_load_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> free)
		else $error("emitter loaded while results still pending");

	a_load_shows_first: assert property (@(posedge clk) disable iff (!arst_n)
		load && bundle.num != 3'd0 |=> out_valid && out_item == $past(bundle.res[0]))
		else $error("first result of a loaded item not presented");

	a_last_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.last |-> idx_q + 3'd1 == cnt_q)
		else $error("string-ending result is not the final one of its item");

endmodule

FILE: src/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder top level: input register, string state, encoder
// and result buffer. Depends on u2u8_pkg, u2u8_encoder and u2u8_emitter.
//
// Usage: each input item carries one UTF-16 code unit and an end-of-string flag
// on in_item with in_valid/in_ready. Each result item carries one UTF-8 byte,
// a status, the running byte count and a last flag on out_item with
// out_valid/out_ready. A string ends with a terminator (byte 0, last set) or
// with an error result (last set); after an error, units are dropped with no
// result until the unit flagged end-of-string.
// An accepted item waits in the input register until the result buffer is free,
// then moves into it; its first result is presented from the result buffer.
// An item occupies the result buffer until all its results are taken, one per
// cycle on the output channel while the receiver is ready: 1 to 4 data bytes
// plus the terminator on the last unit, or a single error result; items that
// cause no result (a held high surrogate, dropped units) leave it free for the next item.
// The single output port of the result buffer limits this rate.
// Reset clears the string state and both buffers and sets the capacity to
// 65535. When the receiver stalls, the current result holds and in_ready falls
// once the input register is occupied; nothing is lost.
// cfg_we writes cfg_wdata to the output capacity; write only while idle.
module utf16_to_utf8_transcoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  u2u8_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output u2u8_pkg::out_item_t  out_item
);

	logic                 item_valid_s1;
	u2u8_pkg::in_item_t   item_s1;
	u2u8_pkg::str_state_t state_q;
	u2u8_pkg::str_state_t state_next;
	u2u8_pkg::bundle_t    bundle;
	logic [15:0]          capacity_q;
	logic                 free;
	logic                 consume;

	assign consume = item_valid_s1 && free;
	assign in_ready = !item_valid_s1 || free;

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= 16'hFFFF;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// String state advances when an item moves into the result buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (consume) begin
			state_q <= state_next;
		end
	end

	u2u8_encoder u_encoder (
		.item     (item_s1),
		.st       (state_q),
		.capacity (capacity_q),
		.bundle   (bundle),
		.st_next  (state_next)
	);

	u2u8_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (consume),
		.bundle    (bundle),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for utf16_to_utf8_transcoder: directed and random UTF-16 strings
// are checked against a built-in UTF-8 encoder model under random stalls on both channels.
// Depends on u2u8_pkg and the transcoder RTL.
module tb;

	localparam int SETTLE_CYCLES = 10;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SHOWN_LIMIT   = 10;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [15:0]         cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	u2u8_pkg::in_item_t  in_item = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	u2u8_pkg::out_item_t out_item;

	// Model copy of the capacity register and of the per-string state.
	logic [15:0] capacity = 16'hFFFF;
	logic [9:0]  held_high = '0;
	logic        held_valid = 1'b0;
	logic [15:0] string_bytes = '0;
	logic        skip_rest = 1'b0;

	u2u8_pkg::out_item_t utf8_expected[$];
	int mismatches = 0;
	int units_sent = 0;
	int cycle_count = 0;
	int sender_idle_pct = 6;
	int receiver_stall_pct = 61;

	utf16_to_utf8_transcoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic void log_failure(input string what);
		mismatches++;
		if (mismatches <= SHOWN_LIMIT)
			$display("%0t: %s", $time, what);
	endfunction

	// Appends one expected result carrying the current byte count.
	function automatic void push_result(input logic [7:0] b, input logic [1:0] st,
			input logic lst);
		u2u8_pkg::out_item_t r;
		r.out_byte = b;
		r.status = st;
		r.byte_count = string_bytes;
		r.last = lst;
		utf8_expected.push_back(r);
	endfunction

	function automatic void clear_string();
		held_high = '0;
		held_valid = 1'b0;
		string_bytes = '0;
		skip_rest = 1'b0;
	endfunction

	// An error closes the string; the rest of it is skipped unless this was its end.
	function automatic void end_on_error(input logic [1:0] st, input logic eos);
		push_result(8'h00, st, 1'b1);
		if (eos) begin
			clear_string();
		end else begin
			held_valid = 1'b0;
			held_high = '0;
			skip_rest = 1'b1;
		end
	endfunction

	// Predicts the UTF-8 results of one code unit. Returns 0 when the unit is skipped.
	function automatic bit encode_unit(input u2u8_pkg::in_item_t it);
		logic [15:0] u;
		logic        eos;
		logic [20:0] cp;
		logic [7:0]  enc [4];
		int          n;
		int          i;
		u = it.code_unit;
		eos = it.end_of_string;
		if (skip_rest) begin
			if (eos)
				clear_string();
			return 1'b0;
		end

		// Resolve the code point, pairing surrogates.
		if (held_valid) begin
			if (u < u2u8_pkg::LO_SURR_FIRST || u > u2u8_pkg::LO_SURR_LAST) begin
				end_on_error(u2u8_pkg::STATUS_SURR_ERR, eos);
				return 1'b1;
			end
			cp = u2u8_pkg::SUPP_BASE + {1'b0, held_high, u[9:0]};
			held_valid = 1'b0;
			held_high = '0;
		end else if (u >= u2u8_pkg::HI_SURR_FIRST && u <= u2u8_pkg::HI_SURR_LAST) begin
			if (eos) begin
				end_on_error(u2u8_pkg::STATUS_SURR_ERR, eos);
			end else begin
				held_high = u[9:0];
				held_valid = 1'b1;
			end
			return 1'b1;
		end else if (u >= u2u8_pkg::LO_SURR_FIRST && u <= u2u8_pkg::LO_SURR_LAST) begin
			end_on_error(u2u8_pkg::STATUS_SURR_ERR, eos);
			return 1'b1;
		end else begin
			cp = {5'd0, u};
		end

		// Split the code point into a lead byte and continuation bytes.
		if (cp < u2u8_pkg::LIMIT_1BYTE) begin
			enc[0] = cp[7:0];
			n = 1;
		end else if (cp < u2u8_pkg::LIMIT_2BYTE) begin
			enc[0] = u2u8_pkg::LEAD_2BYTE | {3'b0, cp[10:6]};
			enc[1] = u2u8_pkg::CONT_MARK | {2'b0, cp[5:0]};
			n = 2;
		end else if (cp < u2u8_pkg::SUPP_BASE) begin
			enc[0] = u2u8_pkg::LEAD_3BYTE | {4'b0, cp[15:12]};
			enc[1] = u2u8_pkg::CONT_MARK | {2'b0, cp[11:6]};
			enc[2] = u2u8_pkg::CONT_MARK | {2'b0, cp[5:0]};
			n = 3;
		end else begin
			enc[0] = u2u8_pkg::LEAD_4BYTE | {5'b0, cp[20:18]};
			enc[1] = u2u8_pkg::CONT_MARK | {2'b0, cp[17:12]};
			enc[2] = u2u8_pkg::CONT_MARK | {2'b0, cp[11:6]};
			enc[3] = u2u8_pkg::CONT_MARK | {2'b0, cp[5:0]};
			n = 4;
		end

		// A code point that does not fit is dropped whole.
		if (int'(string_bytes) + n > int'(capacity)) begin
			end_on_error(u2u8_pkg::STATUS_FULL_ERR, eos);
			return 1'b1;
		end
		for (i = 0; i < n; i++) begin
			string_bytes = string_bytes + 16'd1;
			push_result(enc[i], u2u8_pkg::STATUS_OK, 1'b0);
		end

		// The terminator needs one more byte of room.
		if (eos) begin
			if (string_bytes >= capacity) begin
				end_on_error(u2u8_pkg::STATUS_FULL_ERR, eos);
			end else begin
				push_result(8'h00, u2u8_pkg::STATUS_OK, 1'b1);
				clear_string();
			end
		end
		return 1'b1;
	endfunction

	// Receiver: stalls at random, drives at the falling edge.
	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= receiver_stall_pct);
	end

	// Each accepted result item is compared with the oldest expectation.
	always @(posedge clk) begin
		u2u8_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (utf8_expected.size() == 0) begin
				log_failure($sformatf(
					"unexpected result: byte %02h status %0d count %0d last %0b",
					out_item.out_byte, out_item.status, out_item.byte_count,
					out_item.last));
			end else begin
				want = utf8_expected.pop_front();
				if (out_item.out_byte !== want.out_byte || out_item.status !== want.status ||
						out_item.byte_count !== want.byte_count || out_item.last !== want.last)
					log_failure($sformatf({"result mismatch: expected byte %02h status %0d ",
						"count %0d last %0b, got byte %02h status %0d count %0d last %0b"},
						want.out_byte, want.status, want.byte_count, want.last,
						out_item.out_byte, out_item.status, out_item.byte_count,
						out_item.last));
			end
		end
	end

	// Sends one code unit after a random gap. Called and returns at a falling edge;
	// valid stays high so that a following item can be driven in the same step.
	task automatic send_unit(input logic [15:0] u, input logic eos);
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_item.code_unit = u;
		in_item.end_of_string = eos;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		void'(encode_unit(in_item));
		units_sent++;
		@(negedge clk);
	endtask

	// Holds the sender off until every expected result has arrived.
	task automatic drain_results();
		in_valid = 1'b0;
		while (utf8_expected.size() != 0)
			@(negedge clk);
	endtask

	// Skipped units cause no result, so allow the pipeline to empty as well.
	task automatic settle_block();
		drain_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_capacity(input logic [15:0] value);
		settle_block();
		cfg_wdata = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		capacity = value;
	endtask

	function automatic logic [15:0] pick_bmp_unit();
		case ($urandom_range(3))
			0: return 16'($urandom_range(16'h007F, 16'h0000));
			1: return 16'($urandom_range(16'h07FF, 16'h0080));
			2: return 16'($urandom_range(16'hD7FF, 16'h0800));
			default: return 16'($urandom_range(16'hFFFF, 16'hE000));
		endcase
	endfunction

	// One string of mostly well-formed code points, with some broken pairs and noise.
	task automatic send_random_string();
		int   len;
		int   i;
		int   pick;
		logic eos;
		len = $urandom_range(8, 1);
		for (i = 0; i < len; i++) begin
			eos = (i == len - 1);
			pick = $urandom_range(99);
			if (pick < 55) begin
				send_unit(pick_bmp_unit(), eos);
			end else if (pick < 85) begin
				send_unit(u2u8_pkg::HI_SURR_FIRST | 16'($urandom_range(1023)), 1'b0);
				send_unit(u2u8_pkg::LO_SURR_FIRST | 16'($urandom_range(1023)), eos);
			end else if (pick < 90) begin
				send_unit(u2u8_pkg::HI_SURR_FIRST | 16'($urandom_range(1023)), eos);
			end else if (pick < 95) begin
				send_unit(u2u8_pkg::LO_SURR_FIRST | 16'($urandom_range(1023)), eos);
			end else begin
				send_unit(16'($urandom_range(16'hFFFF)), eos);
			end
		end
	endtask

	task automatic run_traffic(input int send_idle, input int recv_stall,
			input logic [15:0] cap, input int units);
		int start;
		set_capacity(cap);
		sender_idle_pct = send_idle;
		receiver_stall_pct = recv_stall;
		start = units_sent;
		while (units_sent - start < units) begin
			send_random_string();
			// Now and then wait until the block has delivered everything.
			if ($urandom_range(9) == 0)
				drain_results();
		end
	endtask

	// Boundaries of each encoded length, at the capacity left by reset.
	task automatic test_encoding_lengths();
		send_unit(16'h0000, 1'b0);
		send_unit(16'h007F, 1'b0);
		send_unit(16'h0080, 1'b0);
		send_unit(16'h07FF, 1'b0);
		send_unit(16'h0800, 1'b0);
		send_unit(16'hFFFF, 1'b0);
		send_unit(u2u8_pkg::HI_SURR_FIRST, 1'b0);
		send_unit(u2u8_pkg::LO_SURR_FIRST, 1'b0);
		send_unit(u2u8_pkg::HI_SURR_LAST, 1'b0);
		send_unit(u2u8_pkg::LO_SURR_LAST, 1'b1);
	endtask

	// Broken surrogate pairs, each followed by skipped units where the string goes on.
	task automatic test_surrogate_errors();
		// High surrogate followed by a plain unit.
		send_unit(u2u8_pkg::HI_SURR_FIRST, 1'b0);
		send_unit(16'h0041, 1'b0);
		send_unit(16'h0042, 1'b1);
		// Lone low surrogate inside a string and at its end.
		send_unit(u2u8_pkg::LO_SURR_FIRST, 1'b0);
		send_unit(16'h0043, 1'b1);
		send_unit(u2u8_pkg::LO_SURR_LAST, 1'b1);
		// High surrogate on the last unit.
		send_unit(u2u8_pkg::HI_SURR_LAST, 1'b1);
		// Two high surrogates in a row.
		send_unit(u2u8_pkg::HI_SURR_FIRST, 1'b0);
		send_unit(u2u8_pkg::HI_SURR_LAST, 1'b0);
		send_unit(16'h0000, 1'b1);
	endtask

	task automatic test_capacity_limits();
		// Room for one byte only: the terminator does not fit.
		set_capacity(16'd1);
		send_unit(16'h0041, 1'b1);
		// A three-byte code point that does not fit, then a skipped unit.
		set_capacity(16'd2);
		send_unit(16'h0800, 1'b0);
		send_unit(16'h0041, 1'b1);
		// A four-byte code point that exactly fills the capacity.
		set_capacity(16'd4);
		send_unit(16'hD83D, 1'b0);
		send_unit(16'hDE00, 1'b1);
		// Capacity lowered in the middle of a string.
		set_capacity(16'hFFFF);
		send_unit(16'h0041, 1'b0);
		set_capacity(16'd2);
		send_unit(16'h00E9, 1'b1);
	endtask

	// Random strings: sender idles lightly, then the receiver, then neither.
	task automatic test_random_traffic();
		run_traffic(6, 61, 16'hFFFF, 45);
		run_traffic(61, 6, 16'($urandom_range(24, 4)), 45);
		run_traffic(0, 0, 16'($urandom_range(12, 1)), 45);
		run_traffic(0, 0, 16'hFFFF, 45);
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_encoding_lengths();
		test_surrogate_errors();
		test_capacity_limits();
		test_random_traffic();
		settle_block();
		if (mismatches == 0 && utf8_expected.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
